>>> hdl/mme_pkg.sv
// Shared types, constants and helpers for the matrix multiply engine.
// Used by the controller, the datapath and the top level; no dependencies.
package mme_pkg;

    // Matrix dimensions and number formats
    localparam int MAX_DIM     = 8;
    localparam int DIM_W       = $clog2(MAX_DIM);
    localparam int CNT_W       = $clog2(MAX_DIM + 1);
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = 2 * DIM_W;
    localparam int VALUE_W     = 32;
    localparam int ACC_W       = 64;
    localparam int FRAC_W      = 16;

    // Configuration port
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 1'b1;
    localparam logic [CFG_W-1:0]     DIM_RESET      = CFG_W'(MAX_DIM);

    // Input item kinds
    localparam logic CMD_LOAD_A   = 1'b0;
    localparam logic CMD_STREAM_B = 1'b1;

    // Stream widths
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic             take_item;   // latch a right-matrix item
        logic             store_we;    // write a left-matrix element
        logic             issue;       // start one row through the MAC pipe
        logic             emit_load;   // load one result into the output register
        logic             emit_last;   // result is the last of its column
        logic [DIM_W-1:0] row;         // row for issue or emit
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic pipe_busy;   // products still on their way to the accumulators
        logic out_free;    // output register can take a result this cycle
    } t_dp_stat;

    // Map a register value onto the usable range 1..MAX_DIM
    function automatic logic [CNT_W-1:0] clamp_dim(input logic [CFG_W-1:0] r);
        logic [CNT_W-1:0] d;
        if (r == '0) begin
            d = CNT_W'(1);
        end else if (CNT_W'(r) > CNT_W'(MAX_DIM)) begin
            d = CNT_W'(MAX_DIM);
        end else begin
            d = CNT_W'(r);
        end
        return d;
    endfunction

endpackage

>>> hdl/matrix_multiply_engine.sv
// Top level of the matrix multiply engine (C = A x B, Q16.16 in, Q32.32 sums).
// Instantiates mme_ctrl and mme_datapath; depends on mme_pkg.
//
//  Channel   Direction  Handshake        Payload
//  s_axis    in         tvalid/tready    tdata: row_index, col_index, value; tuser: cmd
//  m_axis    out        tvalid/tready    tdata: result_value, result_row, result_col;
//                                        tuser: saturated; tlast: last
//  cfg       in         i_cfg_we         i_cfg_index, i_cfg_wdata (rows_a, inner_size)
//
//  Loads and ignored items are accepted in the idle state. A right-matrix item is swept over
//  the active rows by the single shared multiply-accumulate pipe (store read, multiply,
//  accumulate), then drained, and its results are emitted when it completes a column.
//  Reset is synchronous, active low; accumulators clear, the store is not cleared.
//  A stalled output holds the sequencer in its emit phase;
//  once the last result of a column sits in the output register, the next item is accepted.
module matrix_multiply_engine import mme_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [2:0] row_index, [5:3] col_index,
                                                   // [37:6] value, [39:38] zero
    input  logic [0:0]             s_axis_tuser,   // [0] cmd
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] result_value, [34:32] result_row,
                                                   // [37:35] result_col, [39:38] zero
    output logic [0:0]             m_axis_tuser,   // [0] saturated
    output logic                   m_axis_tlast,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_wdata
);

    t_dp_cmd                   w_cmd;
    t_dp_stat                  w_stat;
    logic [DIM_W-1:0]          w_in_row;
    logic [DIM_W-1:0]          w_in_col;
    logic signed [VALUE_W-1:0] w_in_value;
    logic signed [VALUE_W-1:0] w_out_value;
    logic [DIM_W-1:0]          w_out_row;
    logic [DIM_W-1:0]          w_out_col;
    logic                      w_out_sat;

    // Unpack the input item
    assign w_in_row   = s_axis_tdata[DIM_W-1:0];
    assign w_in_col   = s_axis_tdata[2*DIM_W-1:DIM_W];
    assign w_in_value = s_axis_tdata[2*DIM_W +: VALUE_W];

    mme_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_cmd    (s_axis_tuser[0]),
        .i_in_row    (w_in_row),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    mme_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_row    (w_in_row),
        .i_in_col    (w_in_col),
        .i_in_value  (w_in_value),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_value (w_out_value),
        .o_out_row   (w_out_row),
        .o_out_col   (w_out_col),
        .o_out_sat   (w_out_sat),
        .o_out_last  (m_axis_tlast)
    );

    // Pack the result item
    assign m_axis_tdata = {{(OUT_TDATA_W - VALUE_W - 2*DIM_W){1'b0}},
                           w_out_col, w_out_row, w_out_value};
    assign m_axis_tuser = w_out_sat;

    // No new item while products are still in the MAC pipe
    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.pipe_busy |-> !s_axis_tready)
        else $error("input accepted while MAC pipe busy");

    // Results are emitted only after every product has been summed
    a_emit_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit_load |-> (!w_stat.pipe_busy && !w_cmd.take_item && !w_cmd.store_we))
        else $error("result emitted while accumulators still updating");

    // A clipped result carries one of the two range limits
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
            (m_axis_tdata[VALUE_W-1:0] == 32'h7FFF_FFFF ||
             m_axis_tdata[VALUE_W-1:0] == 32'h8000_0000))
        else $error("saturated flag without a limit value");

endmodule

>>> hdl/mme_ctrl.sv
// Controller of the matrix multiply engine: configuration registers and the
// sequencer that steps rows through the datapath. Depends on mme_pkg.
module mme_ctrl import mme_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_in_cmd,
    input  logic [DIM_W-1:0]     i_in_row,
    input  t_dp_stat             i_stat,
    output t_dp_cmd              o_cmd
);

    t_state             r_state, n_state;
    logic [DIM_W-1:0]   r_row, n_row;
    logic               r_complete, n_complete;
    logic [CFG_W-1:0]   r_rows_a;
    logic [CFG_W-1:0]   r_inner_size;

    logic [CNT_W-1:0]   w_nrows;
    logic [CNT_W-1:0]   w_ninner;
    logic               w_accept;
    logic               w_k_ok;
    logic               w_k_last;
    logic               w_row_last;

    assign w_nrows    = clamp_dim(r_rows_a);
    assign w_ninner   = clamp_dim(r_inner_size);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_k_ok     = CNT_W'(i_in_row) < w_ninner;
    assign w_k_last   = CNT_W'(i_in_row) == (w_ninner - CNT_W'(1));
    assign w_row_last = CNT_W'(r_row) == (w_nrows - CNT_W'(1));

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a     <= DIM_RESET;
            r_inner_size <= DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ROWS_A:     r_rows_a     <= i_cfg_wdata;
                REG_INNER_SIZE: r_inner_size <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_complete = r_complete;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_in_cmd == CMD_STREAM_B && w_k_ok) begin
                    n_state    = ST_MAC;
                    n_row      = '0;
                    n_complete = w_k_last;
                end
            end
            ST_MAC: begin
                if (w_row_last) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_row = r_row + DIM_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_row   = '0;
                    n_state = r_complete ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    if (w_row_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_row = r_row + DIM_W'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands and handshake
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.store_we  = w_accept && i_in_cmd == CMD_LOAD_A;
                o_cmd.take_item = w_accept && i_in_cmd == CMD_STREAM_B && w_k_ok;
            end
            ST_MAC: begin
                o_cmd.issue = 1'b1;
                o_cmd.row   = r_row;
            end
            ST_DRAIN: ;
            ST_EMIT: begin
                o_cmd.emit_load = i_stat.out_free;
                o_cmd.emit_last = w_row_last;
                o_cmd.row       = r_row;
            end
            default: ;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_row      <= '0;
            r_complete <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_row      <= n_row;
            r_complete <= n_complete;
        end
    end

endmodule

>>> hdl/mme_datapath.sv
// Datapath of the matrix multiply engine: left-matrix store, shared
// multiply-accumulate pipe, row accumulators and output register. Depends on mme_pkg.
module mme_datapath import mme_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_stat                  o_stat,
    input  logic [DIM_W-1:0]          i_in_row,
    input  logic [DIM_W-1:0]          i_in_col,
    input  logic signed [VALUE_W-1:0] i_in_value,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [VALUE_W-1:0] o_out_value,
    output logic [DIM_W-1:0]          o_out_row,
    output logic [DIM_W-1:0]          o_out_col,
    output logic                      o_out_sat,
    output logic                      o_out_last
);

    localparam logic signed [ACC_W-1:0]   ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]   ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam int HI_LSB = FRAC_W + VALUE_W - 1;

    logic [VALUE_W-1:0]        r_store [STORE_DEPTH];
    logic signed [VALUE_W-1:0] r_b_value;
    logic [DIM_W-1:0]          r_b_k;
    logic [DIM_W-1:0]          r_b_col;

    logic signed [VALUE_W-1:0] r_rd_data;
    logic                      r_s1_valid;
    logic [DIM_W-1:0]          r_s1_row;
    logic signed [ACC_W-1:0]   r_prod;
    logic                      r_s2_valid;
    logic [DIM_W-1:0]          r_s2_row;

    logic signed [ACC_W-1:0]   r_acc [MAX_DIM];

    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_out_value;
    logic [DIM_W-1:0]          r_out_row;
    logic [DIM_W-1:0]          r_out_col;
    logic                      r_out_sat;
    logic                      r_out_last;

    logic signed [ACC_W-1:0]   w_prod;
    logic [DIM_W-1:0]          w_acc_idx;
    logic signed [ACC_W-1:0]   w_acc_rd;
    logic signed [ACC_W-1:0]   w_sum;
    logic                      w_sum_ovf;
    logic signed [ACC_W-1:0]   w_acc_new;
    logic [ACC_W-HI_LSB-1:0]   w_hi;
    logic                      w_res_ovf;
    logic signed [VALUE_W-1:0] w_res;

    // Hold the right-matrix item for the whole row sweep
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_b_value <= i_in_value;
            r_b_k     <= i_in_row;
            r_b_col   <= i_in_col;
        end
    end

    // Left-matrix store: write on load, registered read for the MAC pipe
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_we) begin
            r_store[{i_in_row, i_in_col}] <= i_in_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_store[{i_cmd.row, r_b_k}];
    end

    // Exact 32x32 signed product, registered
    assign w_prod = ACC_W'(r_rd_data) * ACC_W'(r_b_value);

    always_ff @(posedge i_clk) begin
        r_s1_row <= i_cmd.row;
        r_prod   <= w_prod;
        r_s2_row <= r_s1_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.issue;
            r_s2_valid <= r_s1_valid;
        end
    end

    // One accumulator read port: pipe tail while summing, emit row otherwise
    assign w_acc_idx = r_s2_valid ? r_s2_row : i_cmd.row;
    assign w_acc_rd  = r_acc[w_acc_idx];

    // Saturating add at the signed 64-bit bounds
    assign w_sum     = w_acc_rd + r_prod;
    assign w_sum_ovf = (w_acc_rd[ACC_W-1] == r_prod[ACC_W-1]) &&
                       (w_sum[ACC_W-1] != r_prod[ACC_W-1]);
    assign w_acc_new = w_sum_ovf ? (r_prod[ACC_W-1] ? ACC_MIN : ACC_MAX) : w_sum;

    // Update on the pipe tail, clear on emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_DIM; i++) begin
                r_acc[i] <= '0;
            end
        end else if (r_s2_valid) begin
            r_acc[r_s2_row] <= w_acc_new;
        end else if (i_cmd.emit_load) begin
            r_acc[i_cmd.row] <= '0;
        end
    end

    // Drop the low fraction bits, clip to Q16.16
    assign w_hi      = w_acc_rd[ACC_W-1:HI_LSB];
    assign w_res_ovf = !((&w_hi) || !(|w_hi));
    assign w_res     = w_res_ovf ? (w_acc_rd[ACC_W-1] ? VAL_MIN : VAL_MAX)
                                 : w_acc_rd[FRAC_W +: VALUE_W];

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_out_value <= w_res;
            r_out_row   <= i_cmd.row;
            r_out_col   <= r_b_col;
            r_out_sat   <= w_res_ovf;
            r_out_last  <= i_cmd.emit_last;
        end
    end

    assign o_stat.pipe_busy = i_cmd.issue || r_s1_valid || r_s2_valid;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_sat   = r_out_sat;
    assign o_out_last  = r_out_last;

endmodule
